>>> hw/rtl/rk2cu_pkg.sv
`default_nettype none
package rk2cu_pkg;

  localparam int VAL_W       = 32;
  localparam int NQ          = 5;
  localparam int NVEL        = 3;
  localparam int DT_W        = 31;
  localparam int IDX_W       = 12;
  localparam int FRAC_W      = 16;
  localparam int DIV_NUM_W   = VAL_W + FRAC_W;
  localparam int IN_TDATA_W  = 336;
  localparam int OUT_TDATA_W = NQ * VAL_W;
  localparam int CELLS_DEF   = 4096;

  localparam logic [VAL_W-1:0] VMAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] VMIN = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic {
    OP_STEP    = 1'b0,
    OP_AVERAGE = 1'b1
  } op_t;

  typedef logic signed [VAL_W-1:0] val_t;

  function automatic val_t sat65(input logic signed [64:0] x);
    if (x > 65'sd2147483647) begin
      return val_t'(VMAX);
    end else if (x < -65'sd2147483648) begin
      return val_t'(VMIN);
    end else begin
      return val_t'(x[VAL_W-1:0]);
    end
  endfunction

endpackage
`default_nettype wire

>>> hw/rtl/rk2cu_ram.sv
`default_nettype none
module rk2cu_ram #(
  parameter int WIDTH = 160,
  parameter int DEPTH = 4096,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

>>> hw/rtl/rk2cu_div.sv
`default_nettype none
module rk2cu_div
  import rk2cu_pkg::*;
#(
  parameter int NUM_W = DIV_NUM_W,
  parameter int DEN_W = VAL_W
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [NUM_W-1:0] num,
  input  wire logic [DEN_W-1:0] den,
  output logic      [NUM_W-1:0] quo
);

  // one quotient bit per stage; nq shifts numerator bits out, quotient bits in
  logic [DEN_W-1:0] rem_r [NUM_W];
  logic [NUM_W-1:0] nq_r  [NUM_W];
  logic [DEN_W-1:0] den_r [NUM_W];

  function automatic logic [DEN_W+NUM_W-1:0] step(input logic [DEN_W-1:0] rem,
                                                  input logic [NUM_W-1:0] nq,
                                                  input logic [DEN_W-1:0] d);
    logic [DEN_W:0]   t;
    logic [DEN_W:0]   r;
    logic             b;
    t = {rem, nq[NUM_W-1]};
    b = (t >= {1'b0, d});
    r = b ? (t - {1'b0, d}) : t;
    return {r[DEN_W-1:0], nq[NUM_W-2:0], b};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      {rem_r[0], nq_r[0]} <= step('0, num, den);
      den_r[0] <= den;
      for (int i = 1; i < NUM_W; i++) begin
        {rem_r[i], nq_r[i]} <= step(rem_r[i-1], nq_r[i-1], den_r[i-1]);
        den_r[i] <= den_r[i-1];
      end
    end
  end

  assign quo = nq_r[NUM_W-1];

endmodule
`default_nettype wire

>>> hw/rtl/rk2_cell_update_unit.sv
// Heun (two-stage Runge-Kutta) update of one grid cell per request.
// Input stream in_*: tdata = cell_index, density, mom_x, mom_y, mom_z, energy,
// d_density, d_mom_x, d_mom_y, d_mom_z, d_energy (low bits first);
// tuser = op (0 first stage, saves the cell; 1 second stage, averages).
// Output stream out_*: tdata = new_density, vel_x, vel_y, vel_z, new_energy;
// tuser = div_fault. One result per request, in order.
// cfg_wr_en/cfg_wr_data load the time step; write only while idle.
// Throughput: one request per cycle while out_tready does not stall. Pipeline:
// 3 arithmetic stages, 48-stage bit-per-stage divider for the velocities,
// output register. The save store is one RAM, written and read
// when a request is accepted, so a second stage may directly follow its first.
// The whole pipeline advances only when the output register is empty or taken;
// a stall on out_tready holds every stage and drops in_tready.
// Reset clears the pipeline valid bits and the time step; the save store
// keeps no reset, and a second stage on a never-saved cell is undefined.
`default_nettype none
module rk2_cell_update_unit
  import rk2cu_pkg::*;
#(
  parameter int CELLS = CELLS_DEF
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_wr_en,
  input  wire logic [DT_W-1:0]        cfg_wr_data,
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  // cell_index, density, mom_x, mom_y, mom_z, energy, d_density, d_mom_x,
  // d_mom_y, d_mom_z, d_energy, zero pad
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // op
  input  wire logic [0:0]             in_tuser,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  // new_density, vel_x, vel_y, vel_z, new_energy
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  // div_fault
  output logic [0:0]                  out_tuser
);

  localparam int AW  = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int DL  = DIV_NUM_W;
  localparam int RS  = 26;
  localparam longint RM = ((64'd1 << RS) + CELLS - 1) / CELLS;
  localparam int RMW = RS + 1;

  logic adv;
  logic accept;
  logic [AW-1:0] idx;
  logic [IDX_W-1:0] cell_in;
  logic [DT_W-1:0] dt_r;

  assign cell_in   = in_tdata[IDX_W-1:0];
  assign adv       = !out_tvalid || out_tready;
  assign in_tready = adv;
  assign accept    = in_tvalid && in_tready;

  generate
    if (CELLS == 1) begin : g_one
      assign idx = '0;
    end else if (CELLS >= (1 << IDX_W)) begin : g_wide
      assign idx = AW'(cell_in);
    end else if ((CELLS & (CELLS - 1)) == 0) begin : g_pow2
      assign idx = cell_in[AW-1:0];
    end else begin : g_recip
      logic [IDX_W+RMW-1:0] prod;
      logic [IDX_W-1:0]     q;
      logic [IDX_W+AW-1:0]  qc;
      assign prod = {{RMW{1'b0}}, cell_in} * {{IDX_W{1'b0}}, RMW'(RM)};
      assign q    = prod[RS +: IDX_W];
      assign qc   = {{AW{1'b0}}, q} * (IDX_W+AW)'(CELLS);
      assign idx  = AW'(cell_in - qc[IDX_W-1:0]);
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dt_r <= '0;
    end else if (cfg_wr_en) begin
      dt_r <= cfg_wr_data;
    end
  end

  logic [NQ*VAL_W-1:0] saved_rd;

  rk2cu_ram #(
    .WIDTH (NQ * VAL_W),
    .DEPTH (CELLS)
  ) u_save (
    .clk   (clk),
    .we    (accept && (op_t'(in_tuser[0]) == OP_STEP)),
    .waddr (idx),
    .wdata (in_tdata[IDX_W +: NQ*VAL_W]),
    .re    (accept),
    .raddr (idx),
    .rdata (saved_rd)
  );

  // stage 1: captured request
  logic v1_r;
  op_t  op1_r;
  val_t cur1_r  [NQ];
  val_t rate1_r [NQ];

  // stage 2: products
  logic v2_r;
  op_t  op2_r;
  val_t cur2_r  [NQ];
  val_t sav2_r  [NQ];
  logic signed [63:0] prod2_r [NQ];

  // stage 3: updated values
  logic v3_r;
  val_t upd3_r [NQ];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= accept;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    logic signed [64:0] acc;
    if (adv) begin
      op1_r <= op_t'(in_tuser[0]);
      op2_r <= op1_r;
      for (int i = 0; i < NQ; i++) begin
        cur1_r[i]  <= val_t'(in_tdata[IDX_W + i*VAL_W +: VAL_W]);
        rate1_r[i] <= val_t'(in_tdata[IDX_W + (NQ+i)*VAL_W +: VAL_W]);
        cur2_r[i]  <= cur1_r[i];
        sav2_r[i]  <= val_t'(saved_rd[i*VAL_W +: VAL_W]);
        prod2_r[i] <= $signed({1'b0, dt_r}) * rate1_r[i];
        if (op2_r == OP_STEP) begin
          acc = 65'(cur2_r[i]) - 65'(prod2_r[i] >>> FRAC_W);
        end else begin
          acc = ((65'(sav2_r[i]) + 65'(cur2_r[i])) <<< FRAC_W) - 65'(prod2_r[i]);
          acc = acc >>> (FRAC_W + 1);
        end
        upd3_r[i] <= sat65(acc);
      end
    end
  end

  // divider feed and side delay line
  logic fault3;
  assign fault3 = (upd3_r[0] <= 0);

  logic [DIV_NUM_W-1:0] quo [NVEL];

  for (genvar k = 0; k < NVEL; k++) begin : g_div
    logic [VAL_W-1:0]     mag;
    logic [DIV_NUM_W-1:0] num;
    assign mag = upd3_r[k+1][VAL_W-1] ? (VAL_W)'(-upd3_r[k+1]) : upd3_r[k+1];
    assign num = {mag, {FRAC_W{1'b0}}};
    rk2cu_div u_div (
      .clk (clk),
      .en  (adv),
      .num (num),
      .den (upd3_r[0]),
      .quo (quo[k])
    );
  end

  logic             vd_r    [DL];
  val_t             rho_d_r [DL];
  val_t             en_d_r  [DL];
  logic             flt_d_r [DL];
  logic [NVEL-1:0]  neg_d_r [DL];
  logic [NVEL-1:0]  zer_d_r [DL];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < DL; i++) begin
        vd_r[i] <= 1'b0;
      end
    end else if (adv) begin
      vd_r[0] <= v3_r;
      for (int i = 1; i < DL; i++) begin
        vd_r[i] <= vd_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      rho_d_r[0] <= upd3_r[0];
      en_d_r[0]  <= upd3_r[NQ-1];
      flt_d_r[0] <= fault3;
      for (int k = 0; k < NVEL; k++) begin
        neg_d_r[0][k] <= upd3_r[k+1][VAL_W-1];
        zer_d_r[0][k] <= (upd3_r[k+1] == 0);
      end
      for (int i = 1; i < DL; i++) begin
        rho_d_r[i] <= rho_d_r[i-1];
        en_d_r[i]  <= en_d_r[i-1];
        flt_d_r[i] <= flt_d_r[i-1];
        neg_d_r[i] <= neg_d_r[i-1];
        zer_d_r[i] <= zer_d_r[i-1];
      end
    end
  end

  // output register
  logic out_valid_r;
  logic [OUT_TDATA_W-1:0] out_data_r;
  logic [OUT_TDATA_W-1:0] out_data_nxt;
  logic out_fault_r;

  always_comb begin
    logic [VAL_W-1:0] v;
    out_data_nxt = '0;
    out_data_nxt[0 +: VAL_W] = rho_d_r[DL-1];
    out_data_nxt[(NQ-1)*VAL_W +: VAL_W] = en_d_r[DL-1];
    for (int k = 0; k < NVEL; k++) begin
      if (zer_d_r[DL-1][k]) begin
        v = '0;
      end else if (flt_d_r[DL-1]) begin
        v = neg_d_r[DL-1][k] ? VMIN : VMAX;
      end else if (neg_d_r[DL-1][k]) begin
        v = (quo[k] > DIV_NUM_W'(VMIN)) ? VMIN : VAL_W'(-quo[k]);
      end else begin
        v = (quo[k] > DIV_NUM_W'(VMAX)) ? VMAX : quo[k][VAL_W-1:0];
      end
      out_data_nxt[(k+1)*VAL_W +: VAL_W] = v;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= vd_r[DL-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_data_r  <= out_data_nxt;
      out_fault_r <= flt_d_r[DL-1];
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_fault_r;

endmodule
`default_nettype wire

>>> tb/tb.sv
`timescale 1ns / 1ps
module tb
  import rk2cu_pkg::*;
();

  typedef struct {
    logic signed [31:0] rho;
    logic signed [31:0] vx;
    logic signed [31:0] vy;
    logic signed [31:0] vz;
    logic signed [31:0] en;
    logic fault;
  } cell_res_t;

  class cell_scoreboard;
    logic [30:0] dt;
    logic signed [31:0] saved[int][NQ];
    cell_res_t pending[$];
    int errors;
    int shown;

    function new();
      dt = '0;
      errors = 0;
      shown = 0;
    endfunction

    function longint floor_shr(longint x, int n);
      return x >>> n;
    endfunction

    function longint clamp(longint x);
      if (x > 64'sd2147483647) return 64'sd2147483647;
      if (x < -64'sd2147483648) return -64'sd2147483648;
      return x;
    endfunction

    function void note_request(op_t op, logic [11:0] idx,
                               logic signed [31:0] cur[NQ], logic signed [31:0] rate[NQ]);
      longint upd[NQ];
      longint prod, acc, m, v, rho;
      logic signed [31:0] vel[3];
      cell_res_t r;
      for (int i = 0; i < NQ; i++) begin
        prod = longint'(dt) * longint'(rate[i]);
        if (op == OP_STEP) begin
          upd[i] = clamp(longint'(cur[i]) - floor_shr(prod, 16));
        end else begin
          acc = (longint'(saved[idx][i]) + longint'(cur[i])) * 65536 - prod;
          upd[i] = clamp(floor_shr(acc, 17));
        end
      end
      if (op == OP_STEP) begin
        for (int i = 0; i < NQ; i++) saved[idx][i] = cur[i];
      end
      rho = upd[0];
      for (int i = 0; i < 3; i++) begin
        m = upd[i + 1];
        if (rho <= 0) v = (m > 0) ? 64'sd2147483647 : ((m < 0) ? -64'sd2147483648 : 0);
        else v = clamp((m * 65536) / rho);
        vel[i] = v[31:0];
      end
      r.rho = rho[31:0];
      r.vx = vel[0];
      r.vy = vel[1];
      r.vz = vel[2];
      r.en = upd[4][31:0];
      r.fault = rho <= 0;
      pending = {pending, r};
    endfunction

    function void check_result(logic [OUT_TDATA_W-1:0] d, logic f);
      cell_res_t e;
      cell_res_t a;
      if (pending.size() == 0) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("unexpected result %h", d);
        end
        return;
      end
      e = pending.pop_front();
      a.rho = d[31:0];
      a.vx = d[63:32];
      a.vy = d[95:64];
      a.vz = d[127:96];
      a.en = d[159:128];
      a.fault = f;
      if (a != e) begin
        errors++;
        if (shown < 10) begin
          shown++;
          $display("mismatch exp rho %h v %h %h %h e %h f %b / got rho %h v %h %h %h e %h f %b",
                   e.rho, e.vx, e.vy, e.vz, e.en, e.fault,
                   a.rho, a.vx, a.vy, a.vz, a.en, a.fault);
        end
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic cfg_wr_en = 0;
  logic [DT_W-1:0] cfg_wr_data = '0;
  logic in_tvalid = 0;
  logic in_tready;
  logic [IN_TDATA_W-1:0] in_tdata = '0;
  logic [0:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [0:0] out_tuser;

  cell_scoreboard sb = new();
  int send_idle = 27;
  int recv_idle = 58;
  longint cycles = 0;
  logic [11:0] written[$];

  rk2_cell_update_unit i_dut (
    .clk(clk), .rst_n(rst_n), .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .in_tuser(in_tuser), .out_tvalid(out_tvalid), .out_tready(out_tready),
    .out_tdata(out_tdata), .out_tuser(out_tuser)
  );

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("tb: errors");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser[0]);
    out_tready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic signed [31:0] rand_val(int shape);
    case (shape)
      0: return 32'sh7fffffff;
      1: return 32'sh80000000;
      2: return 32'sd0;
      3: return $signed($urandom_range(32'h00200000, 32'h00010000));
      4: return $signed(32'h0 - $urandom_range(32'h00100000));
      default: return $signed($urandom);
    endcase
  endfunction

  task automatic send(op_t op, logic [11:0] idx,
                      logic signed [31:0] cur[NQ], logic signed [31:0] rate[NQ]);
    logic [IN_TDATA_W-1:0] d;
    d = '0;
    d[11:0] = idx;
    for (int i = 0; i < NQ; i++) begin
      d[12 + 32*i +: 32] = cur[i];
      d[172 + 32*i +: 32] = rate[i];
    end
    while ($urandom_range(99) < send_idle) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tdata <= d;
    in_tuser <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(op, idx, cur, rate);
    if (op == OP_STEP) written = {written, idx};
  endtask

  task automatic send_random(bit avg_ok);
    logic signed [31:0] cur[NQ];
    logic signed [31:0] rate[NQ];
    logic [11:0] idx;
    op_t op;
    int shp;
    shp = $urandom_range(9);
    for (int i = 0; i < NQ; i++) begin
      cur[i] = rand_val(shp < 6 ? ((i == 0) ? 3 : 5) : $urandom_range(6));
      rate[i] = rand_val(shp < 6 ? 4 : $urandom_range(6));
      if (shp < 6) rate[i] = rate[i] >>> $urandom_range(12);
    end
    if (avg_ok && written.size() > 0 && $urandom_range(1)) begin
      op = OP_AVERAGE;
      idx = written[$urandom_range(written.size() - 1)];
    end else begin
      op = OP_STEP;
      idx = 12'($urandom_range(4095));
    end
    send(op, idx, cur, rate);
  endtask

  task automatic drain();
    in_tvalid <= 0;
    while (sb.pending.size() > 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic set_dt(logic [30:0] v);
    @(posedge clk);
    cfg_wr_en <= 1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 0;
    sb.dt = v;
  endtask

  initial begin
    logic signed [31:0] c[NQ];
    logic signed [31:0] r[NQ];
    logic [30:0] steps[5];
    steps = '{31'h0000_8000, 31'h7fff_ffff, 31'h0, 31'h0000_0100, 31'h0001_0000};
    repeat (4) @(posedge clk);
    rst_n <= 1;
    set_dt(31'h0001_0000);
    for (int k = 0; k < 20; k++) begin
      for (int i = 0; i < NQ; i++) begin
        c[i] = rand_val(k % 6);
        r[i] = rand_val((k + i) % 6);
      end
      if (k == 6) c[0] = 32'sd0;
      if (k == 7) begin
        c[0] = 32'sd0;
        c[1] = 32'sd5;
        c[2] = -32'sd5;
        c[3] = 0;
        r = '{0, 0, 0, 0, 0};
      end
      send(k % 2 ? OP_AVERAGE : OP_STEP, k % 2 ? written[$] : ((k == 4) ? 12'hfff : 12'(k)),
           c, r);
    end
    drain();
    for (int ph = 0; ph < 5; ph++) begin
      set_dt(steps[ph]);
      if (ph == 2) begin
        send_idle = 58;
        recv_idle = 27;
      end
      if (ph == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      for (int n = 0; n < 136; n++) begin
        if (n == 70) drain();
        send_random(1);
      end
      drain();
    end
    if (sb.errors == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end
endmodule
